/* sv/rhc_pkg.sv */
package rhc_pkg;

	localparam int CHANNEL_BITS      = 8;
	localparam int HUE_FRACTION_BITS = 8;

	localparam int CW       = CHANNEL_BITS;
	localparam int FW       = HUE_FRACTION_BITS;
	localparam int HUE_W    = FW + 3;
	localparam int LIGHT_W  = CW + 1;
	localparam int HUE_Q_W  = FW + 1;
	localparam int SECT_W   = 3;

	// one quotient bit per stage for each divider that has bits left, both run side by side
	localparam int DIV_STAGES = (HUE_Q_W > CW) ? HUE_Q_W : CW;

	localparam logic [CW-1:0]      FULL      = {CW{1'b1}};
	localparam logic [LIGHT_W-1:0] TWO_FULL  = {FULL, 1'b0};
	localparam logic [HUE_W-1:0]   HUE_TURN  = HUE_W'(6) << FW;

	localparam logic [SECT_W-1:0] BASE_RED   = SECT_W'(0);
	localparam logic [SECT_W-1:0] BASE_GREEN = SECT_W'(2);
	localparam logic [SECT_W-1:0] BASE_BLUE  = SECT_W'(4);
	localparam logic [SECT_W-1:0] BASE_WRAP  = SECT_W'(6);

	typedef struct packed {
		logic [CW:0]        hue_rem;
		logic [HUE_Q_W-1:0] hue_quo;
		logic [CW:0]        sat_rem;
		logic [CW-1:0]      sat_quo;
		logic [CW-1:0]      sat_low;
		logic [CW-1:0]      c;
		logic [CW-1:0]      den;
		logic               neg;
		logic [SECT_W-1:0]  base;
		logic               grey;
		logic [LIGHT_W-1:0] sum;
	} div_t;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [CW-1:0]      sat;
		logic [LIGHT_W-1:0] light;
	} out_t;

endpackage

/* sv/rgb_to_hsl_converter.sv */
// rgb to hsl converter, one pixel beat per clock while the receiver does not stall
//
// pixel channel: red, green, blue (unsigned) qualified by pixel_valid, a beat
// is taken when pixel_valid is high and pixel_stall is low.
// hsl channel: hue (sextants times 2^fraction bits), saturation and
// lightness_doubled (max + min) qualified by hsl_valid, taken when hsl_valid
// is high and hsl_stall is low.
//
// the pipeline has one stage for max/min, one for the divider operands, one
// stage per quotient bit of the two restoring dividers (hue offset and
// saturation run in parallel), and the output register. throughput is one
// pixel per clock while the receiver does not stall.
//
// reset clears every stage valid bit, so no beat is presented after reset.
// when the receiver stalls with a beat waiting, the whole pipeline holds and
// pixel_stall is raised in the same cycle; nothing is dropped or repeated.
module rgb_to_hsl_converter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  logic [rhc_pkg::CHANNEL_BITS-1:0]    red,
	input  logic [rhc_pkg::CHANNEL_BITS-1:0]    green,
	input  logic [rhc_pkg::CHANNEL_BITS-1:0]    blue,
	output logic                                hsl_valid,
	input  logic                                hsl_stall,
	output logic [rhc_pkg::HUE_W-1:0]           hue,
	output logic [rhc_pkg::CHANNEL_BITS-1:0]    saturation,
	output logic [rhc_pkg::LIGHT_W-1:0]         lightness_doubled
);
	import rhc_pkg::*;

	logic en;

	logic          valid_s1;
	logic [CW-1:0] r_s1, g_s1, b_s1, hi_s1, lo_s1;
	logic [CW-1:0] hi_d, lo_d;

	logic  div_valid_s [0:DIV_STAGES];
	div_t  div_s       [0:DIV_STAGES];
	div_t  div_d       [0:DIV_STAGES];

	logic  out_valid_s;
	out_t  out_s;
	out_t  out_d;

	assign en          = !(out_valid_s && hsl_stall);
	assign pixel_stall = !en;

	// max and min
	always_comb begin
		hi_d = red;
		lo_d = red;
		if (green > hi_d) hi_d = green;
		if (blue > hi_d)  hi_d = blue;
		if (green < lo_d) lo_d = green;
		if (blue < lo_d)  lo_d = blue;
	end

	// divider operands
	always_comb begin
		logic [CW-1:0]   c;
		logic [CW-1:0]   a, s;
		logic [2*CW-1:0] num;
		div_t            d;
		c   = hi_s1 - lo_s1;
		num = {c, {CW{1'b0}}} - {{CW{1'b0}}, c};
		d.sum = {1'b0, hi_s1} + {1'b0, lo_s1};
		if (d.sum <= {1'b0, FULL}) begin
			d.den = d.sum[CW-1:0];
		end else begin
			d.den = CW'(TWO_FULL - d.sum);
		end
		priority if (hi_s1 == g_s1) begin
			a = b_s1;
			s = r_s1;
			d.base = BASE_GREEN;
		end else if (hi_s1 == b_s1) begin
			a = r_s1;
			s = g_s1;
			d.base = BASE_BLUE;
		end else begin
			a = g_s1;
			s = b_s1;
			d.base = (g_s1 < b_s1) ? BASE_WRAP : BASE_RED;
		end
		d.neg     = a < s;
		d.hue_rem = {1'b0, (d.neg ? (s - a) : (a - s))};
		d.hue_quo = '0;
		d.sat_rem = {1'b0, num[2*CW-1:CW]};
		d.sat_quo = '0;
		d.sat_low = num[CW-1:0];
		d.c       = c;
		d.grey    = (c == '0);
		div_d[0]  = d;
	end

	// one quotient bit per stage for each divider that has bits left
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_comb begin
			div_t        p;
			logic [CW:0] t;
			logic        q;
			p = div_s[k-1];
			if (k <= HUE_Q_W) begin
				q = p.hue_rem >= {1'b0, p.c};
				t = q ? (p.hue_rem - {1'b0, p.c}) : p.hue_rem;
				p.hue_rem = {t[CW-1:0], 1'b0};
				p.hue_quo = {p.hue_quo[HUE_Q_W-2:0], q};
			end
			if (k <= CW) begin
				t = {p.sat_rem[CW-1:0], p.sat_low[CW-1]};
				q = t >= {1'b0, p.den};
				p.sat_rem = q ? (t - {1'b0, p.den}) : t;
				p.sat_low = {p.sat_low[CW-2:0], 1'b0};
				p.sat_quo = {p.sat_quo[CW-2:0], q};
			end
			div_d[k] = p;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (en) begin
				div_valid_s[k] <= div_valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k] <= div_d[k];
			end
		end
	end

	// hue assembly with wrap, grey forces zero hue and saturation
	always_comb begin
		div_t             p;
		logic [HUE_W-1:0] base_w, q_w, h;
		p      = div_s[DIV_STAGES];
		base_w = HUE_W'(p.base) << FW;
		q_w    = HUE_W'(p.hue_quo);
		h      = p.neg ? (base_w - q_w) : (base_w + q_w);
		if (h >= HUE_TURN) begin
			h = h - HUE_TURN;
		end
		out_d.hue   = p.grey ? '0 : h;
		out_d.sat   = p.grey ? '0 : p.sat_quo;
		out_d.light = p.sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			div_valid_s[0] <= 1'b0;
			out_valid_s    <= 1'b0;
		end else if (en) begin
			valid_s1       <= pixel_valid;
			div_valid_s[0] <= valid_s1;
			out_valid_s    <= div_valid_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1     <= red;
			g_s1     <= green;
			b_s1     <= blue;
			hi_s1    <= hi_d;
			lo_s1    <= lo_d;
			div_s[0] <= div_d[0];
			out_s    <= out_d;
		end
	end

	assign hsl_valid         = out_valid_s;
	assign hue               = out_s.hue;
	assign saturation        = out_s.sat;
	assign lightness_doubled = out_s.light;

endmodule

/* sv/rhc_checker.sv */
module rhc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_stall,
	input  logic                                hsl_valid,
	input  logic                                hsl_stall,
	input  logic [rhc_pkg::HUE_W-1:0]           hue,
	input  logic [rhc_pkg::CHANNEL_BITS-1:0]    saturation,
	input  logic [rhc_pkg::LIGHT_W-1:0]         lightness_doubled
);
	import rhc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && hsl_stall |=> hsl_valid)
		else $error("hsl beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && hsl_stall |=> $stable(hue) && $stable(saturation)
			&& $stable(lightness_doubled))
		else $error("hsl payload changed while stalled");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hue < HUE_TURN)
		else $error("hue beyond one turn");

	a_grey_ends: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && (lightness_doubled == '0 || lightness_doubled == TWO_FULL)
			|-> hue == '0 && saturation == '0)
		else $error("black or white pixel with nonzero hue or saturation");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> hsl_valid && hsl_stall)
		else $error("pixel stall without a stalled hsl beat");

endmodule

bind rgb_to_hsl_converter rhc_checker u_rhc_checker (.*);

/* verif/hsl_checker.sv */
module hsl_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pixel_valid,
	input  logic                        pixel_stall,
	input  logic [rhc_pkg::CW-1:0]      red,
	input  logic [rhc_pkg::CW-1:0]      green,
	input  logic [rhc_pkg::CW-1:0]      blue,
	input  logic                        hsl_valid,
	input  logic                        hsl_stall,
	input  logic [rhc_pkg::HUE_W-1:0]   hue,
	input  logic [rhc_pkg::CW-1:0]      saturation,
	input  logic [rhc_pkg::LIGHT_W-1:0] lightness_doubled,
	output int                          fail_count,
	output int                          pending
);
	import rhc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	out_t hsl_expected[$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic out_t predict_hsl(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b);
		int rr, gg, bb, hi, lo, c, sum, h, s, dev, den, diff, base, sextant, full;
		out_t res;
		rr = int'(r);
		gg = int'(g);
		bb = int'(b);
		full = int'(FULL);
		sextant = 1 << FW;
		hi = rr;
		lo = rr;
		if (gg > hi) hi = gg;
		if (bb > hi) hi = bb;
		if (gg < lo) lo = gg;
		if (bb < lo) lo = bb;
		c = hi - lo;
		sum = hi + lo;
		h = 0;
		s = 0;
		if (c != 0) begin
			if (hi == gg) begin
				base = 2;
				diff = bb - rr;
			end else if (hi == bb) begin
				base = 4;
				diff = rr - gg;
			end else begin
				base = (gg < bb) ? 6 : 0;
				diff = gg - bb;
			end
			// signed division truncates toward zero
			h = base * sextant + (diff * sextant) / c;
			if (h >= 6 * sextant) h = h - 6 * sextant;
			if (h < 0) h = 0;
			dev = sum - full;
			if (dev < 0) dev = -dev;
			den = full - dev;
			if (den > 0) begin
				s = (c * full) / den;
				if (s > full) s = full;
			end
		end
		res.hue = HUE_W'(h);
		res.sat = CW'(s);
		res.light = LIGHT_W'(sum);
		return res;
	endfunction

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (hsl_valid && !hsl_stall) begin
				if (hsl_expected.size() == 0) begin
					$display("%0t: unexpected hsl beat hue %0d sat %0d light %0d",
						$time, hue, saturation, lightness_doubled);
					fail_count++;
				end else begin
					want = hsl_expected.pop_front();
					if (hue !== want.hue) begin
						$display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
						fail_count++;
					end
					if (saturation !== want.sat) begin
						$display("%0t: saturation expected %0d actual %0d",
							$time, want.sat, saturation);
						fail_count++;
					end
					if (lightness_doubled !== want.light) begin
						$display("%0t: lightness_doubled expected %0d actual %0d",
							$time, want.light, lightness_doubled);
						fail_count++;
					end
				end
			end
			if (pixel_valid && !pixel_stall)
				hsl_expected.push_back(predict_hsl(red, green, blue));
			pending = hsl_expected.size();
		end
	end

endmodule

/* verif/rgb_to_hsl_converter_test.sv */
module rgb_to_hsl_converter_test;
	import rhc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               pixel_valid = 1'b0;
	logic               pixel_stall;
	logic [CW-1:0]      red = '0;
	logic [CW-1:0]      green = '0;
	logic [CW-1:0]      blue = '0;
	logic               hsl_valid;
	logic               hsl_stall = 1'b0;
	logic [HUE_W-1:0]   hue;
	logic [CW-1:0]      saturation;
	logic [LIGHT_W-1:0] lightness_doubled;

	int fail_count;
	int pending;

	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	bit hold_hsl = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	rgb_to_hsl_converter uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.pixel_valid       (pixel_valid),
		.pixel_stall       (pixel_stall),
		.red               (red),
		.green             (green),
		.blue              (blue),
		.hsl_valid         (hsl_valid),
		.hsl_stall         (hsl_stall),
		.hue               (hue),
		.saturation        (saturation),
		.lightness_doubled (lightness_doubled)
	);

	hsl_checker hsl_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.pixel_valid       (pixel_valid),
		.pixel_stall       (pixel_stall),
		.red               (red),
		.green             (green),
		.blue              (blue),
		.hsl_valid         (hsl_valid),
		.hsl_stall         (hsl_stall),
		.hue               (hue),
		.saturation        (saturation),
		.lightness_doubled (lightness_doubled),
		.fail_count        (fail_count),
		.pending           (pending)
	);

	// receiver side stall, long hold counted here
	initial begin
		forever begin
			@(negedge clk);
			if (hold_hsl) begin
				hsl_stall <= 1'b1;
				repeat (80) @(negedge clk);
				hsl_stall <= 1'b0;
				hold_hsl = 1'b0;
			end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
				hsl_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
				hsl_stall <= 1'b0;
			end else begin
				hsl_stall <= 1'b0;
			end
		end
	end

	task automatic send_pixel(input logic [CW-1:0] r, input logic [CW-1:0] g,
		input logic [CW-1:0] b);
		int gap;
		@(negedge clk);
		if (sender_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (pixel_stall);
	endtask

	task automatic send_random(input int count);
		logic [CW-1:0] r, g, b;
		int mode;
		repeat (count) begin
			mode = $urandom_range(0, 9);
			r = CW'($urandom);
			g = CW'($urandom);
			b = CW'($urandom);
			case (mode)
				0: begin
					g = r;
					b = r;
				end
				1: g = r;
				2: b = g;
				3: b = r;
				4: begin
					r = ($urandom_range(0, 1) ? FULL : '0) ^ CW'($urandom_range(0, 1));
					g = ($urandom_range(0, 1) ? FULL : '0) ^ CW'($urandom_range(0, 1));
					b = ($urandom_range(0, 1) ? FULL : '0) ^ CW'($urandom_range(0, 1));
				end
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	task automatic drain_hsl;
		@(negedge clk);
		pixel_valid <= 1'b0;
		wait (pending == 0);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// grey, primaries, ties and the red sector below zero
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd254);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd127, 8'd128, 8'd127);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd200, 8'd100, 8'd50);
		send_pixel(8'd10, 8'd200, 8'd250);
		send_pixel(8'd170, 8'd85, 8'd170);
		send_pixel(8'd85, 8'd170, 8'd85);

		send_random(600);

		// receiver holds off while beats keep coming
		hold_hsl = 1'b1;
		send_random(60);

		// sender waits for every result
		drain_hsl();
		send_random(900);

		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		send_random(340);

		drain_hsl();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/rhc_pkg.sv
sv/rgb_to_hsl_converter.sv
sv/rhc_checker.sv
verif/hsl_checker.sv
verif/rgb_to_hsl_converter_test.sv
